// File: sv/jbl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON byte lexer package
// Shared types, token and error codes, character constants and the keyword
// lookup functions used by the lexer front end, the queue and the back end.
// ----------------------------------------------------------------------------
package jbl_pkg;

  localparam int OFFSET_BITS_DEFAULT = 16;
  localparam int QUEUE_DEPTH         = 4;
  localparam int TDATA_IN_W          = 8;
  localparam int TDATA_OUT_W         = 40;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_STRING,
    MODE_WORD,
    MODE_NUMBER,
    MODE_DROP
  } lex_mode_t;

  // Token kinds.
  localparam logic [3:0] KIND_LBRACE   = 4'd0;
  localparam logic [3:0] KIND_RBRACE   = 4'd1;
  localparam logic [3:0] KIND_LBRACKET = 4'd2;
  localparam logic [3:0] KIND_RBRACKET = 4'd3;
  localparam logic [3:0] KIND_COLON    = 4'd4;
  localparam logic [3:0] KIND_COMMA    = 4'd5;
  localparam logic [3:0] KIND_STRING   = 4'd6;
  localparam logic [3:0] KIND_NUMBER   = 4'd7;
  localparam logic [3:0] KIND_TRUE     = 4'd8;
  localparam logic [3:0] KIND_FALSE    = 4'd9;
  localparam logic [3:0] KIND_NULL     = 4'd10;
  localparam logic [3:0] KIND_END      = 4'd11;
  // Error transactions carry kind zero.
  localparam logic [3:0] KIND_ERROR    = 4'd0;

  // Error codes.
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_BAD_CHAR    = 3'd1;
  localparam logic [2:0] ERR_BAD_KEYWORD = 3'd2;
  localparam logic [2:0] ERR_BAD_NUMBER  = 3'd3;
  localparam logic [2:0] ERR_OPEN_STRING = 3'd4;
  localparam logic [2:0] ERR_TOO_LONG    = 3'd5;

  // Keyword candidates.
  localparam logic [1:0] KW_NONE  = 2'd0;
  localparam logic [1:0] KW_TRUE  = 2'd1;
  localparam logic [1:0] KW_FALSE = 2'd2;
  localparam logic [1:0] KW_NULL  = 2'd3;

  // Characters.
  localparam logic [7:0] CH_LBRACE   = "{";
  localparam logic [7:0] CH_RBRACE   = "}";
  localparam logic [7:0] CH_LBRACKET = "[";
  localparam logic [7:0] CH_RBRACKET = "]";
  localparam logic [7:0] CH_COLON    = ":";
  localparam logic [7:0] CH_COMMA    = ",";
  localparam logic [7:0] CH_QUOTE    = "\"";
  localparam logic [7:0] CH_MINUS    = "-";
  localparam logic [7:0] CH_PLUS     = "+";
  localparam logic [7:0] CH_EXP      = "e";
  localparam logic [7:0] CH_PERIOD   = ".";
  localparam logic [7:0] CH_SPACE    = " ";
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_T        = "t";
  localparam logic [7:0] CH_F        = "f";
  localparam logic [7:0] CH_N        = "n";

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [2:0]  err;
  } token_t;

  // All tokens caused by one input byte, lowest index first.
  typedef struct packed {
    logic [1:0]       count;
    token_t [2:0]     tok;
  } bundle_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic is_numchar(input logic [7:0] b);
    return is_digit(b) || b == CH_MINUS || b == CH_PLUS || b == CH_EXP || b == CH_PERIOD;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] cand);
    logic [2:0] len;
    unique case (cand)
      KW_TRUE:  len = 3'd4;
      KW_FALSE: len = 3'd5;
      KW_NULL:  len = 3'd4;
      default:  len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] cand, input logic [2:0] idx);
    logic [39:0] text;
    unique case (cand)
      KW_TRUE:  text = {"true", 8'h00};
      KW_FALSE: text = "false";
      KW_NULL:  text = {"null", 8'h00};
      default:  text = '0;
    endcase
    text = text << (8 * idx);
    return text[39:32];
  endfunction

  function automatic logic [3:0] kw_kind(input logic [1:0] cand);
    logic [3:0] kind;
    unique case (cand)
      KW_TRUE:  kind = KIND_TRUE;
      KW_FALSE: kind = KIND_FALSE;
      KW_NULL:  kind = KIND_NULL;
      default:  kind = KIND_ERROR;
    endcase
    return kind;
  endfunction

endpackage

// File: sv/jbl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON byte lexer front end
// Accepts one byte per cycle while the queue is not full, runs the lexer
// state and pushes the tokens that the byte causes as one bundle into the queue.
// ----------------------------------------------------------------------------
module jbl_front #(
  parameter int OFFSET_BITS = jbl_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              doc_last,
  input  logic              q_full,
  output logic              push,
  output jbl_pkg::bundle_t  push_bundle
);

  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;
  localparam logic [OFFSET_BITS-1:0] ONE     = OFFSET_BITS'(1);

  jbl_pkg::lex_mode_t     mode, mode_next;
  logic [OFFSET_BITS-1:0] pos, pos_next;
  logic [OFFSET_BITS-1:0] start_off, start_off_next;
  logic [OFFSET_BITS-1:0] run_len, run_len_next;
  logic [1:0]             minus_seen, minus_seen_next;
  logic                   plus_seen, plus_seen_next;
  logic                   exp_seen, exp_seen_next;
  logic                   period_seen, period_seen_next;
  logic [1:0]             kw_cand, kw_cand_next;
  logic                   kw_bad, kw_bad_next;

  jbl_pkg::token_t [2:0]  tok;
  logic [1:0]             n;
  logic                   fail;
  logic [2:0]             err;
  logic                   consumed;
  logic                   restart;
  logic                   accept;

  function automatic jbl_pkg::token_t make_tok(input logic [3:0] kind,
                                               input logic [OFFSET_BITS-1:0] start,
                                               input logic [OFFSET_BITS-1:0] len,
                                               input logic [2:0] code);
    jbl_pkg::token_t t;
    t.kind   = kind;
    t.start  = 16'(start);
    t.length = 16'(len);
    t.err    = code;
    return t;
  endfunction

  // Returns {mismatch, candidate} after one more letter of a word.
  function automatic logic [2:0] kw_feed(input logic [1:0] cand, input logic bad,
                                         input logic [OFFSET_BITS-1:0] rl,
                                         input logic [7:0] b);
    logic [2:0] r;
    r = {bad, cand};
    if (rl == '0) begin
      if (b == jbl_pkg::CH_T)      r = {1'b0, jbl_pkg::KW_TRUE};
      else if (b == jbl_pkg::CH_F) r = {1'b0, jbl_pkg::KW_FALSE};
      else if (b == jbl_pkg::CH_N) r = {1'b0, jbl_pkg::KW_NULL};
      else                         r = {1'b1, jbl_pkg::KW_NONE};
    end else if (cand == jbl_pkg::KW_NONE ||
                 rl >= OFFSET_BITS'(jbl_pkg::kw_len(cand)) ||
                 jbl_pkg::kw_char(cand, rl[2:0]) != b) begin
      r[2] = 1'b1;
    end
    return r;
  endfunction

  function automatic logic word_ok(input logic [1:0] cand, input logic bad,
                                   input logic [OFFSET_BITS-1:0] rl);
    return !bad && cand != jbl_pkg::KW_NONE && rl == OFFSET_BITS'(jbl_pkg::kw_len(cand));
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= jbl_pkg::MODE_IDLE;
      pos         <= '0;
      start_off   <= '0;
      run_len     <= '0;
      minus_seen  <= '0;
      plus_seen   <= 1'b0;
      exp_seen    <= 1'b0;
      period_seen <= 1'b0;
      kw_cand     <= jbl_pkg::KW_NONE;
      kw_bad      <= 1'b0;
    end else if (accept) begin
      mode        <= mode_next;
      pos         <= pos_next;
      start_off   <= start_off_next;
      run_len     <= run_len_next;
      minus_seen  <= minus_seen_next;
      plus_seen   <= plus_seen_next;
      exp_seen    <= exp_seen_next;
      period_seen <= period_seen_next;
      kw_cand     <= kw_cand_next;
      kw_bad      <= kw_bad_next;
    end
  end

  always_comb begin
    mode_next        = mode;
    pos_next         = pos;
    start_off_next   = start_off;
    run_len_next     = run_len;
    minus_seen_next  = minus_seen;
    plus_seen_next   = plus_seen;
    exp_seen_next    = exp_seen;
    period_seen_next = period_seen;
    kw_cand_next     = kw_cand;
    kw_bad_next      = kw_bad;
    tok              = '0;
    n                = 2'd0;
    fail             = 1'b0;
    err              = jbl_pkg::ERR_NONE;
    consumed         = 1'b0;
    restart          = 1'b0;

    if (mode == jbl_pkg::MODE_DROP) begin
      restart = doc_last;
    end else if (pos == POS_MAX) begin
      fail = 1'b1;
      err  = jbl_pkg::ERR_TOO_LONG;
    end else begin
      // Continue or close the open run.
      unique case (mode)
        jbl_pkg::MODE_STRING: begin
          if (in_byte == jbl_pkg::CH_QUOTE) begin
            tok[n]    = make_tok(jbl_pkg::KIND_STRING, start_off, run_len, jbl_pkg::ERR_NONE);
            n         = n + 2'd1;
            mode_next = jbl_pkg::MODE_IDLE;
          end else begin
            run_len_next = run_len + ONE;
          end
          consumed = 1'b1;
        end
        jbl_pkg::MODE_WORD: begin
          if (jbl_pkg::is_alpha(in_byte)) begin
            {kw_bad_next, kw_cand_next} = kw_feed(kw_cand, kw_bad, run_len, in_byte);
            run_len_next = run_len + ONE;
            consumed     = 1'b1;
          end else if (!word_ok(kw_cand, kw_bad, run_len)) begin
            fail = 1'b1;
            err  = jbl_pkg::ERR_BAD_KEYWORD;
          end else begin
            tok[n]    = make_tok(jbl_pkg::kw_kind(kw_cand), start_off, run_len,
                                 jbl_pkg::ERR_NONE);
            n         = n + 2'd1;
            mode_next = jbl_pkg::MODE_IDLE;
          end
        end
        jbl_pkg::MODE_NUMBER: begin
          if (jbl_pkg::is_numchar(in_byte)) begin
            if (in_byte == jbl_pkg::CH_MINUS) begin
              if (minus_seen == 2'd2) fail = 1'b1;
              else minus_seen_next = minus_seen + 2'd1;
            end else if (in_byte == jbl_pkg::CH_PLUS) begin
              if (plus_seen) fail = 1'b1;
              else plus_seen_next = 1'b1;
            end else if (in_byte == jbl_pkg::CH_EXP) begin
              if (exp_seen) fail = 1'b1;
              else exp_seen_next = 1'b1;
            end else if (in_byte == jbl_pkg::CH_PERIOD) begin
              if (period_seen) fail = 1'b1;
              else period_seen_next = 1'b1;
            end
            if (fail) err = jbl_pkg::ERR_BAD_NUMBER;
            run_len_next = run_len + ONE;
            consumed     = 1'b1;
          end else begin
            tok[n]    = make_tok(jbl_pkg::KIND_NUMBER, start_off, run_len, jbl_pkg::ERR_NONE);
            n         = n + 2'd1;
            mode_next = jbl_pkg::MODE_IDLE;
          end
        end
        default: ;
      endcase

      // Lex the byte itself when no run took it.
      if (!fail && !consumed) begin
        unique case (in_byte)
          jbl_pkg::CH_LBRACE: begin
            tok[n] = make_tok(jbl_pkg::KIND_LBRACE, pos, ONE, jbl_pkg::ERR_NONE);
            n      = n + 2'd1;
          end
          jbl_pkg::CH_RBRACE: begin
            tok[n] = make_tok(jbl_pkg::KIND_RBRACE, pos, ONE, jbl_pkg::ERR_NONE);
            n      = n + 2'd1;
          end
          jbl_pkg::CH_LBRACKET: begin
            tok[n] = make_tok(jbl_pkg::KIND_LBRACKET, pos, ONE, jbl_pkg::ERR_NONE);
            n      = n + 2'd1;
          end
          jbl_pkg::CH_RBRACKET: begin
            tok[n] = make_tok(jbl_pkg::KIND_RBRACKET, pos, ONE, jbl_pkg::ERR_NONE);
            n      = n + 2'd1;
          end
          jbl_pkg::CH_COLON: begin
            tok[n] = make_tok(jbl_pkg::KIND_COLON, pos, ONE, jbl_pkg::ERR_NONE);
            n      = n + 2'd1;
          end
          jbl_pkg::CH_COMMA: begin
            tok[n] = make_tok(jbl_pkg::KIND_COMMA, pos, ONE, jbl_pkg::ERR_NONE);
            n      = n + 2'd1;
          end
          jbl_pkg::CH_QUOTE: begin
            mode_next      = jbl_pkg::MODE_STRING;
            start_off_next = pos + ONE;
            run_len_next   = '0;
          end
          default: begin
            if (jbl_pkg::is_alpha(in_byte)) begin
              mode_next      = jbl_pkg::MODE_WORD;
              start_off_next = pos;
              run_len_next   = ONE;
              {kw_bad_next, kw_cand_next} = kw_feed(jbl_pkg::KW_NONE, 1'b0, '0, in_byte);
            end else if (in_byte == jbl_pkg::CH_MINUS || jbl_pkg::is_digit(in_byte)) begin
              mode_next        = jbl_pkg::MODE_NUMBER;
              start_off_next   = pos;
              run_len_next     = ONE;
              minus_seen_next  = (in_byte == jbl_pkg::CH_MINUS) ? 2'd1 : 2'd0;
              plus_seen_next   = 1'b0;
              exp_seen_next    = 1'b0;
              period_seen_next = 1'b0;
            end else if (!jbl_pkg::is_space(in_byte)) begin
              fail = 1'b1;
              err  = jbl_pkg::ERR_BAD_CHAR;
            end
          end
        endcase
      end

      // The final byte closes an open word or number run; an open string is an error.
      if (!fail) begin
        if (doc_last) begin
          if (mode_next == jbl_pkg::MODE_WORD) begin
            if (!word_ok(kw_cand_next, kw_bad_next, run_len_next)) begin
              fail = 1'b1;
              err  = jbl_pkg::ERR_BAD_KEYWORD;
            end else begin
              tok[n] = make_tok(jbl_pkg::kw_kind(kw_cand_next), start_off_next,
                                run_len_next, jbl_pkg::ERR_NONE);
              n      = n + 2'd1;
            end
          end else if (mode_next == jbl_pkg::MODE_NUMBER) begin
            tok[n] = make_tok(jbl_pkg::KIND_NUMBER, start_off_next, run_len_next,
                              jbl_pkg::ERR_NONE);
            n      = n + 2'd1;
          end else if (mode_next == jbl_pkg::MODE_STRING) begin
            fail = 1'b1;
            err  = jbl_pkg::ERR_OPEN_STRING;
          end
          if (!fail) begin
            tok[n]  = make_tok(jbl_pkg::KIND_END, pos + ONE, '0, jbl_pkg::ERR_NONE);
            n       = n + 2'd1;
            restart = 1'b1;
          end
        end else begin
          pos_next = pos + ONE;
        end
      end
    end

    if (fail) begin
      tok[n]    = make_tok(jbl_pkg::KIND_ERROR, pos, '0, err);
      n         = n + 2'd1;
      mode_next = jbl_pkg::MODE_DROP;
      restart   = doc_last;
    end

    if (restart) begin
      mode_next        = jbl_pkg::MODE_IDLE;
      pos_next         = '0;
      start_off_next   = '0;
      run_len_next     = '0;
      minus_seen_next  = '0;
      plus_seen_next   = 1'b0;
      exp_seen_next    = 1'b0;
      period_seen_next = 1'b0;
      kw_cand_next     = jbl_pkg::KW_NONE;
      kw_bad_next      = 1'b0;
    end
  end

  assign push              = accept && (n != 2'd0);
  assign push_bundle.count = n;
  assign push_bundle.tok   = tok;

endmodule

// File: sv/jbl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON byte lexer token queue
// Short first-in first-out buffer of token bundles between the front end and
// the back end.
// ----------------------------------------------------------------------------
module jbl_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  jbl_pkg::bundle_t  push_bundle,
  output logic              full,
  input  logic              pop,
  output jbl_pkg::bundle_t  head,
  output logic              head_valid
);

  localparam int PTR_W = $clog2(jbl_pkg::QUEUE_DEPTH);

  jbl_pkg::bundle_t mem [jbl_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;
  logic             mem_empty;
  logic             head_free;
  logic             mem_wr;
  logic             mem_rd;

  // The oldest bundle sits in the head register; the array holds the rest.
  // A push into an empty queue goes straight to the head register.
  assign full      = (fill == (PTR_W + 1)'(jbl_pkg::QUEUE_DEPTH));
  assign mem_empty = (wr_ptr == rd_ptr);
  assign head_free = !head_valid || pop;
  assign mem_rd    = head_free && !mem_empty;
  assign mem_wr    = push && !(head_free && mem_empty);

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[wr_ptr] <= push_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      head <= mem[rd_ptr];
    end else if (push && head_free) begin
      head <= push_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fill       <= '0;
      head_valid <= 1'b0;
    end else begin
      if (mem_wr) wr_ptr <= wr_ptr + PTR_W'(1);
      if (mem_rd) rd_ptr <= rd_ptr + PTR_W'(1);
      if (head_free) head_valid <= mem_rd || push;
      if (push && !pop)      fill <= fill + (PTR_W + 1)'(1);
      else if (pop && !push) fill <= fill - (PTR_W + 1)'(1);
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("bundle pushed into a full queue");
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("bundle popped from an empty queue");
  a_head_before_array: assert property (@(posedge clk) disable iff (rst)
      !head_valid |-> mem_empty)
    else $error("bundles stored behind an empty head register");
`endif

endmodule

// File: sv/jbl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON byte lexer back end
// Unpacks the bundle at the head of the queue into single token transactions
// and holds each in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module jbl_back (
  input  logic              clk,
  input  logic              rst,
  input  jbl_pkg::bundle_t  head,
  input  logic              head_valid,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output jbl_pkg::token_t   out_tok,
  output logic              out_last
);

  logic [1:0] idx;
  logic       last_sub;
  logic       load;

  assign last_sub = (idx == head.count - 2'd1);
  assign load     = head_valid && (!out_valid || out_ready);
  assign pop      = load && last_sub;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (load) idx <= last_sub ? 2'd0 : idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tok  <= head.tok[idx];
      out_last <= last_sub;
    end
  end

`ifndef SYNTHESIS
  a_idx_needs_head: assert property (@(posedge clk) disable iff (rst)
      idx != 2'd0 |-> head_valid)
    else $error("token index advanced with no bundle at the queue head");
  a_error_ends_run: assert property (@(posedge clk) disable iff (rst)
      out_valid && out_tok.err != jbl_pkg::ERR_NONE |-> out_last)
    else $error("error token is not the last token of its byte");
`endif

endmodule

// File: sv/json_byte_lexer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON byte lexer
// Turns a JSON byte stream into token descriptors: kind, start, length, error.
// ----------------------------------------------------------------------------
// The slave stream carries the document, one byte per transaction, with tlast
// on the final byte. The master stream carries one token per transaction;
// tlast marks the last token caused by a given input byte. A byte may cause no
// token (whitespace, string body) or up to three (a closed number, a
// punctuation mark and the end token).
// The tokens of an accepted byte pass through the queue's head register and then
// the output register, which drives the master port; a bundle that finds the
// queue empty goes straight into the head register.
// Throughput: one byte per cycle while the queue is not full, as long as bytes
// cause at most one token on average; the back end drains one token per cycle
// while the receiver is ready, token by token. A four-bundle queue decouples the
// lexer from the output register, and s_tready drops only when it is full.
// A stalled receiver holds the current token in the output register; the
// queue then fills and backpressure reaches the slave port.
// Reset empties the queue and the output register and starts a new document
// at offset zero. After an error token all bytes up to the document's final
// byte are dropped without output.
// ----------------------------------------------------------------------------
module json_byte_lexer_unit #(
  parameter int OFFSET_BITS = jbl_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [jbl_pkg::TDATA_IN_W-1:0]  s_tdata,   // [7:0] in_byte
  input  logic                            s_tlast,   // doc_last
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [3:0] token_kind, [19:4] token_start, [35:20] token_length,
  // [38:36] error_code, [39] zero
  output logic [jbl_pkg::TDATA_OUT_W-1:0] m_tdata,
  output logic                            m_tlast    // run_last
);

  logic              push;
  jbl_pkg::bundle_t  push_bundle;
  logic              q_full;
  logic              pop;
  jbl_pkg::bundle_t  head;
  logic              head_valid;
  jbl_pkg::token_t   out_tok;

  // Lexer state machine: classifies each byte and builds its token bundle.
  jbl_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_byte     (s_tdata),
    .doc_last    (s_tlast),
    .q_full      (q_full),
    .push        (push),
    .push_bundle (push_bundle)
  );

  // Bundles wait here so a stalled receiver does not stall the lexer at once.
  jbl_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_bundle (push_bundle),
    .full        (q_full),
    .pop         (pop),
    .head        (head),
    .head_valid  (head_valid)
  );

  // Serializes each bundle into token transactions.
  jbl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_tok    (out_tok),
    .out_last   (m_tlast)
  );

  assign m_tdata = {1'b0, out_tok.err, out_tok.length, out_tok.start, out_tok.kind};

`ifndef SYNTHESIS
  a_error_token_shape: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && out_tok.err != jbl_pkg::ERR_NONE |->
        out_tok.kind == jbl_pkg::KIND_ERROR && out_tok.length == 16'd0)
    else $error("error token with nonzero kind or length");
`endif

endmodule
